// ----- src/i2cm_pkg.sv -----
package i2cm_pkg;

    // bus command codes carried in the func field
    localparam logic [2:0] CMD_IDLE      = 3'd0;
    localparam logic [2:0] CMD_START     = 3'd1;
    localparam logic [2:0] CMD_WRITE     = 3'd2;
    localparam logic [2:0] CMD_READ_ACK  = 3'd3;
    localparam logic [2:0] CMD_READ_NACK = 3'd4;
    localparam logic [2:0] CMD_STOP      = 3'd5;

    // phase numbers inside the byte sequences
    localparam int          PHASE_W          = 5;
    localparam logic [4:0]  PH_LAST_START    = 5'd2;
    localparam logic [4:0]  PH_WR_ACK_DRIVE  = 5'd16;
    localparam logic [4:0]  PH_WR_ACK_SAMPLE = 5'd17;
    localparam logic [4:0]  PH_WR_LAST       = 5'd18;
    localparam logic [4:0]  PH_RD_LAST_BIT   = 5'd16;
    localparam logic [4:0]  PH_RD_ACK_DRIVE  = 5'd17;
    localparam logic [4:0]  PH_RD_ACK_HIGH   = 5'd18;
    localparam logic [4:0]  PH_RD_LAST       = 5'd19;

    // configuration
    localparam logic [7:0] PHASE_TICKS_RST = 8'd5;
    localparam int         APB_AW          = 3;
    localparam int         APB_DW          = 32;

    // stream widths
    localparam int IN_DW  = 16;
    localparam int OUT_DW = 16;

    // engine state
    typedef struct packed {
        logic [7:0]         tick;
        logic [PHASE_W-1:0] phase;
        logic [7:0]         shift;
        logic [2:0]         cmd;
        logic               scl;
        logic               sda;
        logic               nack;
        logic [7:0]         rx_hold;
    } t_state;

    // one result beat
    typedef struct packed {
        logic       nack;
        logic [7:0] rx_byte;
        logic       done_res;
        logic       busy_res;
        logic       sda_release;
        logic       scl_release;
    } t_result;

endpackage

// ----- src/i2cm_step.sv -----
module i2cm_step (
    input  i2cm_pkg::t_state  i_state,
    input  logic [7:0]        i_phase_ticks,
    input  logic [2:0]        i_func,
    input  logic [7:0]        i_tx_byte,
    input  logic              i_sda_sample,
    output i2cm_pkg::t_state  o_state,
    output i2cm_pkg::t_result o_result
);

    i2cm_pkg::t_state n_st;
    logic [7:0]       period;
    logic [7:0]       tick_inc;
    logic             fin;
    logic             adv;

    always_comb begin
        n_st     = i_state;
        fin      = 1'b0;
        adv      = 1'b0;
        period   = (i_phase_ticks == 8'd0) ? 8'd1 : i_phase_ticks;
        tick_inc = 8'd0;

        // launch a command when idle
        if (i_state.cmd == i2cm_pkg::CMD_IDLE &&
            i_func >= i2cm_pkg::CMD_START && i_func <= i2cm_pkg::CMD_STOP) begin
            n_st.cmd   = i_func;
            n_st.phase = '0;
            n_st.tick  = 8'd0;
            n_st.shift = (i_func == i2cm_pkg::CMD_WRITE) ? i_tx_byte : 8'd0;
        end

        if (n_st.cmd != i2cm_pkg::CMD_IDLE) begin
            // pin levels for the current phase
            unique case (n_st.cmd) inside
                i2cm_pkg::CMD_START: begin
                    if (n_st.phase == 5'd0) n_st.sda = 1'b1;
                    else if (n_st.phase == 5'd1) n_st.scl = 1'b1;
                    else n_st.sda = 1'b0;
                end
                i2cm_pkg::CMD_STOP: begin
                    if (n_st.phase == 5'd0) begin
                        n_st.scl = 1'b0;
                        n_st.sda = 1'b0;
                    end else if (n_st.phase == 5'd1) n_st.scl = 1'b1;
                    else n_st.sda = 1'b1;
                end
                i2cm_pkg::CMD_WRITE: begin
                    if (n_st.phase < i2cm_pkg::PH_WR_ACK_DRIVE) begin
                        if (!n_st.phase[0]) begin
                            n_st.scl = 1'b0;
                            n_st.sda = n_st.shift[7];
                        end else n_st.scl = 1'b1;
                    end else if (n_st.phase == i2cm_pkg::PH_WR_ACK_DRIVE) begin
                        n_st.scl = 1'b0;
                        n_st.sda = 1'b1;
                    end else if (n_st.phase == i2cm_pkg::PH_WR_ACK_SAMPLE) n_st.scl = 1'b1;
                    else n_st.scl = 1'b0;
                end
                i2cm_pkg::CMD_READ_ACK, i2cm_pkg::CMD_READ_NACK: begin
                    if (n_st.phase == 5'd0) begin
                        n_st.scl = 1'b0;
                        n_st.sda = 1'b1;
                    end else if (n_st.phase <= i2cm_pkg::PH_RD_LAST_BIT) begin
                        n_st.scl = n_st.phase[0];
                    end else if (n_st.phase == i2cm_pkg::PH_RD_ACK_DRIVE) begin
                        n_st.scl = 1'b0;
                        n_st.sda = (n_st.cmd == i2cm_pkg::CMD_READ_NACK);
                    end else if (n_st.phase == i2cm_pkg::PH_RD_ACK_HIGH) n_st.scl = 1'b1;
                    else n_st.scl = 1'b0;
                end
                default: ;
            endcase

            // phase timer
            tick_inc = n_st.tick + 8'd1;
            if (tick_inc >= period) begin
                n_st.tick = 8'd0;
                // end of phase actions
                unique case (n_st.cmd) inside
                    i2cm_pkg::CMD_START, i2cm_pkg::CMD_STOP: begin
                        if (n_st.phase >= i2cm_pkg::PH_LAST_START) fin = 1'b1;
                        else adv = 1'b1;
                    end
                    i2cm_pkg::CMD_WRITE: begin
                        if (n_st.phase < i2cm_pkg::PH_WR_ACK_DRIVE && n_st.phase[0]) begin
                            n_st.shift = {n_st.shift[6:0], 1'b0};
                            adv        = 1'b1;
                        end else if (n_st.phase == i2cm_pkg::PH_WR_ACK_SAMPLE) begin
                            if (i_sda_sample) begin
                                // no acknowledge: chain into a stop
                                n_st.nack  = 1'b1;
                                n_st.cmd   = i2cm_pkg::CMD_STOP;
                                n_st.phase = '0;
                            end else begin
                                n_st.nack = 1'b0;
                                adv       = 1'b1;
                            end
                        end else if (n_st.phase >= i2cm_pkg::PH_WR_LAST) fin = 1'b1;
                        else adv = 1'b1;
                    end
                    i2cm_pkg::CMD_READ_ACK, i2cm_pkg::CMD_READ_NACK: begin
                        if (n_st.phase >= 5'd1 && n_st.phase <= i2cm_pkg::PH_RD_LAST_BIT &&
                            n_st.phase[0]) begin
                            n_st.shift = {n_st.shift[6:0], i_sda_sample};
                            adv        = 1'b1;
                        end else if (n_st.phase >= i2cm_pkg::PH_RD_LAST) begin
                            n_st.rx_hold = n_st.shift;
                            fin          = 1'b1;
                        end else adv = 1'b1;
                    end
                    default: fin = 1'b1;
                endcase
            end else begin
                n_st.tick = tick_inc;
            end
        end

        if (fin) begin
            n_st.cmd   = i2cm_pkg::CMD_IDLE;
            n_st.phase = '0;
        end else if (adv) begin
            n_st.phase = n_st.phase + 5'd1;
        end
    end

    // result fields
    always_comb begin
        o_state              = n_st;
        o_result.scl_release = n_st.scl;
        o_result.sda_release = n_st.sda;
        o_result.busy_res    = (n_st.cmd != i2cm_pkg::CMD_IDLE);
        o_result.done_res    = fin;
        o_result.rx_byte     = n_st.rx_hold;
        o_result.nack        = n_st.nack;
    end

endmodule

// ----- src/i2cm_out_stage.sv -----
module i2cm_out_stage (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_load,
    input  i2cm_pkg::t_result              i_result,
    output logic                           o_space,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [i2cm_pkg::OUT_DW-1:0]    m_tdata
);

    logic              r_valid;
    i2cm_pkg::t_result r_result;

    // room for a new beat when empty or the held beat leaves now
    assign o_space = !r_valid || m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign m_tvalid = r_valid;
    assign m_tdata  = {{(i2cm_pkg::OUT_DW - $bits(i2cm_pkg::t_result)){1'b0}}, r_result};

endmodule

// ----- src/i2c_master_byte_engine.sv -----
// I2C master byte engine. Every accepted input beat is one bus tick and yields exactly one
// output beat carrying the SCL/SDA release levels, busy, done, the last received byte and the
// nack flag. A beat is taken every clock while the output register can drain, so the engine
// runs at one tick per cycle; an output beat appears in the cycle after its input beat, from
// the result register. Commands (start, write, read with ack or nack, stop) are ignored while
// a command is running; each pin phase lasts phase_ticks ticks (zero acts as one). A write
// that sees no acknowledge sets nack and issues a stop on its own, raising done when the stop
// ends. phase_ticks lives at APB byte address 0 and should only be changed while idle.
module i2c_master_byte_engine (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // apb configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [i2cm_pkg::APB_AW-1:0]  paddr,
    input  logic [i2cm_pkg::APB_DW-1:0]  pwdata,
    output logic [i2cm_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    // input beats
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [i2cm_pkg::IN_DW-1:0]   s_tdata,  // func[2:0], tx_byte[10:3], sda_sample[11]
    // output beats
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [i2cm_pkg::OUT_DW-1:0]  m_tdata   // scl_release[0], sda_release[1],
                                                   // busy_res[2], done_res[3],
                                                   // rx_byte[11:4], nack[12]
);

    logic [7:0]        r_phase_ticks;
    i2cm_pkg::t_state  r_state;
    i2cm_pkg::t_state  n_state;
    i2cm_pkg::t_result step_result;
    logic              out_space;
    logic              in_beat;

    // apb register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {24'd0, r_phase_ticks} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= i2cm_pkg::PHASE_TICKS_RST;
        end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
            r_phase_ticks <= pwdata[7:0];
        end
    end

    // input handshake
    assign s_tready = out_space;
    assign in_beat  = s_tvalid && s_tready;

    i2cm_step u_step (
        .i_state       (r_state),
        .i_phase_ticks (r_phase_ticks),
        .i_func        (s_tdata[2:0]),
        .i_tx_byte     (s_tdata[10:3]),
        .i_sda_sample  (s_tdata[11]),
        .o_state       (n_state),
        .o_result      (step_result)
    );

    // engine state advances once per input beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.tick    <= 8'd0;
            r_state.phase   <= '0;
            r_state.shift   <= 8'd0;
            r_state.cmd     <= i2cm_pkg::CMD_IDLE;
            r_state.scl     <= 1'b1;
            r_state.sda     <= 1'b1;
            r_state.nack    <= 1'b0;
            r_state.rx_hold <= 8'd0;
        end else if (in_beat) begin
            r_state <= n_state;
        end
    end

    i2cm_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (in_beat),
        .i_result (step_result),
        .o_space  (out_space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef NO_ASSERTIONS
    // a finished command never reports busy in the same beat
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> !(m_tdata[3] && m_tdata[2]))
        else $error("done and busy raised together");

    // idle engine holds phase and timer at zero
    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.cmd == i2cm_pkg::CMD_IDLE |-> (r_state.phase == '0 && r_state.tick == 8'd0))
        else $error("idle engine with running phase");

    // phase never runs past the longest sequence
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase <= i2cm_pkg::PH_RD_LAST)
        else $error("phase index out of range");

    // an input beat always lands in the output register
    a_beat_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> m_tvalid)
        else $error("result beat lost");
`endif

endmodule
